// ----- rtl/orlb_pkg.sv -----
// Package for the overwriting ring log buffer.
// Holds action codes, item structs and sizing constants; no dependencies.
`timescale 1ns / 1ps

package orlb_pkg;

    localparam int DEPTH_DEF      = 256;
    localparam int ENTRY_BITS_DEF = 64;
    localparam int ENTRY_W        = 64;   // fixed width of the record fields
    localparam int FILL_W         = 9;    // fixed width of the reported count

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_START = 2'd1,
        ACT_NEXT  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    typedef struct packed {
        action_t              action;
        logic [ENTRY_W-1:0]   entry_in;
    } req_item_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]   entry_out;
        logic [FILL_W-1:0]    fill_count;
    } rsp_item_t;

    // Per-item information carried from the control stage to the read stage
    typedef struct packed {
        logic                 hit;         // read data is a live record
        logic [FILL_W-1:0]    fill_count;
    } rd_info_t;

endpackage

// ----- rtl/orlb_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module orlb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/orlb_ctrl.sv -----
// Pointer and fill-count control for the ring log buffer.
// Issues RAM commands per accepted item. Depends on orlb_pkg.
`timescale 1ns / 1ps

module orlb_ctrl #(
    parameter int  DEPTH  = orlb_pkg::DEPTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  orlb_pkg::action_t   action,
    output logic                wr_en,
    output logic [ADDR_W-1:0]   wr_addr,
    output logic                rd_en,
    output logic [ADDR_W-1:0]   rd_addr,
    output orlb_pkg::rd_info_t  info
);

    import orlb_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;
    logic              full;
    logic              hit;

    function automatic logic [ADDR_W-1:0] step_slot(input logic [ADDR_W-1:0] slot);
        step_slot = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
    endfunction

    assign full = (count_reg == FULL_CNT);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        hit         = 1'b0;
        if (accept)
        begin
            unique case (action)
                ACT_ADD:
                begin
                    wr_en       = 1'b1;
                    wr_ptr_next = step_slot(wr_ptr_reg);
                    if (!full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                ACT_START:
                begin
                    rd_ptr_next = full ? wr_ptr_reg : '0;
                end
                ACT_NEXT:
                begin
                    rd_en       = 1'b1;
                    rd_ptr_next = step_slot(rd_ptr_reg);
                    // until full, only slots below the write pointer were written since clear
                    hit         = full || (rd_ptr_reg < wr_ptr_reg);
                end
                ACT_CLEAR:
                begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    count_next  = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign wr_addr         = wr_ptr_reg;
    assign rd_addr         = rd_ptr_reg;
    assign info.hit        = hit;
    assign info.fill_count = FILL_W'(count_next);

    a_count_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("fill count above depth");

    a_count_tracks_wr : assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (count_reg == CNT_W'(wr_ptr_reg)))
        else $error("write pointer out of step with fill count");

    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == ACT_CLEAR) |=> (count_reg == '0) && (wr_ptr_reg == '0))
        else $error("clear did not empty the buffer");

endmodule

// ----- rtl/overwrite_ring_log_buffer.sv -----
// Top level of the overwriting ring log buffer.
// Items pass stage s1, then the response register; one item per cycle unless stalled.
// Each item makes at most one access to the single record RAM (add writes, next reads).
// Reset (asynchronous, active low) empties the buffer at once; there is no clearing pass,
// since slots unwritten since the last clear are told by fill count and write pointer.
// Depends on orlb_pkg, orlb_ram and orlb_ctrl.
`timescale 1ns / 1ps

module overwrite_ring_log_buffer #(
    parameter int DEPTH      = orlb_pkg::DEPTH_DEF,
    parameter int ENTRY_BITS = orlb_pkg::ENTRY_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  orlb_pkg::req_item_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output orlb_pkg::rsp_item_t  rsp
);

    import orlb_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    // Request side
    logic                  accept;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ENTRY_BITS-1:0] rd_data;
    rd_info_t              info;

    // Read stage: RAM output is valid while s1 holds the item
    logic                  s1_valid_reg, s1_valid_next;
    rd_info_t              s1_info_reg,  s1_info_next;

    // Response register
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_item_t             rsp_reg,       rsp_next;
    logic                  rsp_load;

    // s1 may hand over when the response register is free or emptying this cycle.
    // The RAM read register only updates on accept, so a held s1 keeps its data.
    assign rsp_load  = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !rsp_load;
    assign accept    = req_valid && !req_stall;

    orlb_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .action  (req.action),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .info    (info)
    );

    orlb_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.entry_in[ENTRY_BITS-1:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_info_next  = s1_info_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
            s1_info_next  = info;
        end
        else if (rsp_load)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_load)
        begin
            rsp_valid_next      = 1'b1;
            // records never written since clear read as zero; non-read actions give zero
            rsp_next.entry_out  = s1_info_reg.hit ? ENTRY_W'(rd_data) : '0;
            rsp_next.fill_count = s1_info_reg.fill_count;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        s1_info_reg <= s1_info_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_held_read_stable : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !rsp_load |=> $stable(rd_data))
        else $error("RAM read data changed while read stage held");

    a_stall_only_when_busy : assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && rsp_valid_reg)
        else $error("request stalled with free pipeline");

    a_hit_only_on_next : assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req.action != ACT_NEXT) |=> !s1_info_reg.hit)
        else $error("read hit flagged for a non-read action");

endmodule
